FILE: rtl/core/wcf_pkg.sv
`default_nettype none

package wcf_pkg;

    // Largest image the line store and the position counters are built for.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W     = 8;
    localparam int WIN       = 5;
    localparam int LINE_ROWS = 4;
    localparam int PH_W      = $clog2(LINE_ROWS);

    // Widths of the configuration fields as seen on the register port.
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_MODE_W   = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    // Widths derived from the maximum image size.
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int OROW_W = $clog2(MAX_HEIGHT);
    localparam int ROW_W  = HGT_W + 1;
    localparam int POS_W  = ((HGT_W > WID_W) ? HGT_W : WID_W) + 1;
    localparam int P_W    = ROW_W + WID_W + 1;

    // Kernel sums stay within +-8191 for every mode.
    localparam int SUM_W     = 15;
    localparam int DIV_IN_W  = 13;
    localparam int RECIP_W   = 15;
    localparam int PROD_W    = DIV_IN_W + RECIP_W;
    localparam int DIV_SHIFT = 18;
    localparam logic [RECIP_W-1:0] RECIP9  = 15'd29128;
    localparam logic [RECIP_W-1:0] RECIP25 = 15'd10486;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE  = 2'd2;

    localparam logic [CFG_MODE_W-1:0] MODE_BOX3      = 3'd0;
    localparam logic [CFG_MODE_W-1:0] MODE_BOX5      = 3'd1;
    localparam logic [CFG_MODE_W-1:0] MODE_SHARP3    = 3'd2;
    localparam logic [CFG_MODE_W-1:0] MODE_SHARP3X2  = 3'd3;
    localparam logic [CFG_MODE_W-1:0] MODE_SHARP5    = 3'd4;
    localparam logic [CFG_MODE_W-1:0] MODE_PREWITT_H = 3'd5;
    localparam logic [CFG_MODE_W-1:0] MODE_PREWITT_V = 3'd6;

    localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = 13'd480;

    localparam logic REQ_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [LINE_ROWS-1:0][PIX_W-1:0] t_line;
    typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] t_win;

    localparam t_sum PIX_MAX = 15'sd255;

    typedef struct packed {
        logic [WID_W-1:0]      width;
        logic [HGT_W-1:0]      height;
        logic [CFG_MODE_W-1:0] mode;
        logic                  r2;
    } t_cfg;

    typedef struct packed {
        t_pix              pix;
        logic [PH_W-1:0]   phase;
        logic              emit;
        logic              last;
        logic [OROW_W-1:0] out_row;
        logic [COL_W-1:0]  out_col;
    } t_s1;

    typedef struct packed {
        logic [WIN-1:0] row_use;
        logic [WIN-1:0] col_use;
        logic           last;
    } t_s2;

    // True when window index idx lies inside the kernel radius and the
    // neighbour it stands for lies inside the image.
    function automatic logic tap_ok(input logic [POS_W-1:0] pos,
                                    input logic [POS_W-1:0] lim,
                                    input logic [2:0] idx,
                                    input logic r2);
        logic [2:0] cen;
        logic [2:0] rad;
        logic [2:0] d;
        cen = r2 ? 3'd2 : 3'd3;
        rad = r2 ? 3'd2 : 3'd1;
        if (idx < cen) begin
            d = cen - idx;
            tap_ok = (d <= rad) && (pos >= POS_W'(d));
        end else begin
            d = idx - cen;
            tap_ok = (d <= rad) && ((pos + POS_W'(d)) < lim);
        end
    endfunction

    // Weighted contribution of one window pixel for the selected kernel.
    function automatic t_sum tap_term(input logic [CFG_MODE_W-1:0] mode,
                                      input logic [2:0] a,
                                      input logic [2:0] b,
                                      input logic r2,
                                      input t_pix pix);
        logic [2:0] cen;
        logic       centre;
        t_sum       p;
        t_sum       p9;
        cen    = r2 ? 3'd2 : 3'd3;
        centre = (a == cen) && (b == cen);
        p      = SUM_W'(pix);
        p9     = (p <<< 3) + p;
        case (mode)
            MODE_SHARP3, MODE_SHARP5: begin
                tap_term = centre ? p9 : -p;
            end
            MODE_SHARP3X2: begin
                tap_term = centre ? (p9 <<< 1) : -(p <<< 1);
            end
            MODE_PREWITT_H: begin
                tap_term = (b < cen) ? -p : ((b == cen) ? '0 : p);
            end
            MODE_PREWITT_V: begin
                tap_term = (a < cen) ? -p : ((a == cen) ? '0 : p);
            end
            default: begin
                tap_term = p;
            end
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wcf_ram.sv
`default_nettype none

module wcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/wcf_front.sv
`default_nettype none

module wcf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wcf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  wcf_pkg::t_pix                 i_pixel_in,
    output wcf_pkg::t_cfg                 o_cfg,
    output logic                          o_s1_valid,
    output wcf_pkg::t_s1                  o_s1,
    input  logic                          i_s1_take,
    output logic                          o_ram_re,
    output logic [wcf_pkg::LINE_ROWS-1:0] o_ram_we,
    output logic [wcf_pkg::COL_W-1:0]     o_ram_addr,
    output wcf_pkg::t_pix                 o_ram_wdata
);

    import wcf_pkg::*;

    logic [CFG_WIDTH_W-1:0]  r_image_width;
    logic [CFG_HEIGHT_W-1:0] r_image_height;
    logic [CFG_MODE_W-1:0]   r_kernel_mode;

    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [COL_W-1:0]  r_out_col;
    logic [OROW_W-1:0] r_out_row;
    logic [COL_W-1:0]  n_in_col;
    logic [ROW_W-1:0]  n_in_row;
    logic [COL_W-1:0]  n_out_col;
    logic [OROW_W-1:0] n_out_row;

    logic r_s1_valid;
    t_s1  r_s1;

    logic [WID_W-1:0]      eff_w;
    logic [HGT_W-1:0]      eff_h;
    logic [CFG_MODE_W-1:0] eff_mode;
    logic                  eff_r2;
    logic [WID_W-1:0]      w_m1;
    logic [HGT_W-1:0]      h_m1;
    logic [P_W-1:0]        pos;
    logic [P_W-1:0]        lag;
    logic                  draining;
    logic                  skip;
    logic                  work;
    logic                  emit;
    logic                  last;
    logic                  in_wrap;
    logic                  out_wrap;
    t_pix                  pix_v;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_WIDTH;
            r_image_height <= RST_HEIGHT;
            r_kernel_mode  <= MODE_BOX3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                REG_KERNEL_MODE:  r_kernel_mode  <= i_cfg_data[CFG_MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range settings are clamped; the unused mode code selects box 3x3.
    always_comb begin
        if (r_image_width == '0) begin
            eff_w = WID_W'(1);
        end else if (r_image_width > MAX_WIDTH) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(r_image_width);
        end
        if (r_image_height == '0) begin
            eff_h = HGT_W'(1);
        end else if (r_image_height > MAX_HEIGHT) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end else begin
            eff_h = HGT_W'(r_image_height);
        end
        eff_mode = (r_kernel_mode > MODE_PREWITT_V) ? MODE_BOX3 : r_kernel_mode;
        eff_r2   = (eff_mode == MODE_BOX5) || (eff_mode == MODE_SHARP5);
    end

    assign o_cfg = '{width: eff_w, height: eff_h, mode: eff_mode, r2: eff_r2};

    assign o_in_ready = !r_s1_valid || i_s1_take;

    always_comb begin
        draining = r_in_row >= ROW_W'(eff_h);
        // A drain tick before the frame has ended is taken and dropped.
        skip  = (i_req_type == REQ_DRAIN) && !draining;
        pix_v = draining ? '0 : i_pixel_in;
        work  = i_in_valid && o_in_ready && !skip;

        pos  = P_W'(r_in_row) * P_W'(eff_w) + P_W'(r_in_col);
        lag  = eff_r2 ? ((P_W'(eff_w) << 1) + P_W'(2)) : (P_W'(eff_w) + P_W'(1));
        emit = pos >= lag;

        h_m1 = eff_h - HGT_W'(1);
        w_m1 = eff_w - WID_W'(1);
        last = (HGT_W'(r_out_row) > h_m1)
            || ((HGT_W'(r_out_row) == h_m1) && (WID_W'(r_out_col) >= w_m1));
        in_wrap  = (WID_W'(r_in_col) + WID_W'(1)) >= eff_w;
        out_wrap = WID_W'(r_out_col) >= w_m1;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (work) begin
            if (in_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_wrap) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (o_in_ready) begin
                r_s1_valid <= work;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_s1 <= '{pix: pix_v, phase: r_in_row[PH_W-1:0], emit: emit, last: last,
                      out_row: r_out_row, out_col: r_out_col};
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    // The four older rows are read at the current column while the new pixel
    // is written over the oldest one in its bank.
    always_comb begin
        for (int g = 0; g < LINE_ROWS; g++) begin
            o_ram_we[g] = work && (r_in_row[PH_W-1:0] == PH_W'(g));
        end
    end

    assign o_ram_re    = work;
    assign o_ram_addr  = r_in_col;
    assign o_ram_wdata = pix_v;

endmodule

`default_nettype wire

FILE: rtl/core/wcf_window.sv
`default_nettype none

module wcf_window (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wcf_pkg::t_cfg  i_cfg,
    input  logic           i_s1_valid,
    input  wcf_pkg::t_s1   i_s1,
    output logic           o_s1_take,
    input  wcf_pkg::t_line i_line,
    output logic           o_s2_valid,
    output wcf_pkg::t_s2   o_s2,
    output wcf_pkg::t_win  o_win,
    input  logic           i_s2_take
);

    import wcf_pkg::*;

    t_win r_win;
    t_win n_win;
    logic r_s2_valid;
    t_s2  r_s2;
    t_s2  n_s2;
    logic move;
    logic [WIN-1:0][PIX_W-1:0] new_col;

    assign o_s1_take = !r_s2_valid || i_s2_take;
    assign move      = i_s1_valid && o_s1_take;

    always_comb begin
        // Bottom row is the incoming pixel; the rows above come from the line
        // store banks, newest first.
        new_col[WIN-1] = i_s1.pix;
        for (int k = 1; k < WIN; k++) begin
            new_col[WIN-1-k] = i_line[PH_W'(i_s1.phase - PH_W'(k))];
        end
        for (int a = 0; a < WIN; a++) begin
            for (int b = 0; b < WIN - 1; b++) begin
                n_win[a][b] = r_win[a][b+1];
            end
            n_win[a][WIN-1] = new_col[a];
        end
        for (int a = 0; a < WIN; a++) begin
            n_s2.row_use[a] = tap_ok(POS_W'(i_s1.out_row), POS_W'(i_cfg.height),
                                     3'(a), i_cfg.r2);
            n_s2.col_use[a] = tap_ok(POS_W'(i_s1.out_col), POS_W'(i_cfg.width),
                                     3'(a), i_cfg.r2);
        end
        n_s2.last = i_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_s1_take) begin
            r_s2_valid <= i_s1_valid && i_s1.emit;
        end
    end

    // Every pixel shifts the window, also those that produce no output.
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_win <= n_win;
            r_s2  <= n_s2;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;
    assign o_win      = r_win;

endmodule

`default_nettype wire

FILE: rtl/core/wcf_arith.sv
`default_nettype none

module wcf_arith (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wcf_pkg::t_cfg i_cfg,
    input  logic          i_s2_valid,
    input  wcf_pkg::t_s2  i_s2,
    input  wcf_pkg::t_win i_win,
    output logic          o_s2_take,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output wcf_pkg::t_pix o_pixel_out,
    output logic          o_frame_last
);

    import wcf_pkg::*;

    logic r_s3_valid;
    t_sum r_row_sum [WIN];
    logic r_s3_last;
    t_sum n_row_sum [WIN];

    logic r_s4_valid;
    t_sum r_s4_sum;
    logic r_s4_last;
    t_sum n_total;

    logic r_out_valid;
    t_pix r_out_pix;
    logic r_out_last;

    logic                 rdy3;
    logic                 rdy4;
    logic                 rdy_out;
    logic                 box;
    logic [RECIP_W-1:0]   recip;
    logic [PROD_W-1:0]    prod;
    t_pix                 res;

    assign rdy_out   = !r_out_valid || i_out_ready;
    assign rdy4      = !r_s4_valid || rdy_out;
    assign rdy3      = !r_s3_valid || rdy4;
    assign o_s2_take = rdy3;

    // Row sums over the masked window.
    always_comb begin
        for (int a = 0; a < WIN; a++) begin
            n_row_sum[a] = '0;
            for (int b = 0; b < WIN; b++) begin
                if (i_s2.row_use[a] && i_s2.col_use[b]) begin
                    n_row_sum[a] = n_row_sum[a]
                        + tap_term(i_cfg.mode, 3'(a), 3'(b), i_cfg.r2, i_win[a][b]);
                end
            end
        end
    end

    always_comb begin
        n_total = '0;
        for (int a = 0; a < WIN; a++) begin
            n_total = n_total + r_row_sum[a];
        end
    end

    // Box averages divide by 9 or 25 through a reciprocal multiply that is
    // exact for every sum the box kernels can reach.
    always_comb begin
        box   = (i_cfg.mode == MODE_BOX3) || (i_cfg.mode == MODE_BOX5);
        recip = (i_cfg.mode == MODE_BOX5) ? RECIP25 : RECIP9;
        prod  = PROD_W'(r_s4_sum[DIV_IN_W-1:0]) * PROD_W'(recip);
        if (box) begin
            res = prod[DIV_SHIFT +: PIX_W];
        end else if (r_s4_sum[SUM_W-1]) begin
            res = '0;
        end else if (r_s4_sum > PIX_MAX) begin
            res = '1;
        end else begin
            res = r_s4_sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy3) begin
                r_s3_valid <= i_s2_valid;
            end
            if (rdy4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (rdy_out) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && i_s2_valid) begin
            r_row_sum <= n_row_sum;
            r_s3_last <= i_s2.last;
        end
        if (rdy4 && r_s3_valid) begin
            r_s4_sum  <= n_total;
            r_s4_last <= r_s3_last;
        end
        if (rdy_out && r_s4_valid) begin
            r_out_pix  <= res;
            r_out_last <= r_s4_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_out_pix;
    assign o_frame_last = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/core/window_convolution_filter_core.sv
`default_nettype none

// Streaming 3x3 / 5x5 window filter for 8-bit grey pixels in raster order. One
// pixel or drain tick is taken per clock and results leave at the same rate while
// i_out_ready holds no result back. The line store is four banks of one row each,
// and every bank does one registered read and at most one write per cycle. An
// accepted item passes the input register, the window shift, the row sums and
// the total, each held in a register of its own, and the divide/saturate step
// then writes its result to the output register. The first result of a frame
// needs r rows plus r pixels of input first (r is 1 for 3x3 kernels, 2 for 5x5).
// After the last pixel of a frame, drain ticks push the remaining results out.
// frame_last marks the final one, and the position counters then return to the
// frame start. Configuration takes effect at once, so change it between frames.
// The line store needs no clearing after reset. Stale entries are read, but they
// only ever land on neighbours outside the image, and those are masked out of the sum.
module window_convolution_filter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [wcf_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [wcf_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                           o_frame_last
);

    import wcf_pkg::*;

    t_cfg                  cfg;
    logic                  s1_valid;
    t_s1                   s1;
    logic                  s1_take;
    logic                  s2_valid;
    t_s2                   s2;
    t_win                  win;
    logic                  s2_take;
    logic                  ram_re;
    logic [LINE_ROWS-1:0]  ram_we;
    logic [COL_W-1:0]      ram_addr;
    t_pix                  ram_wdata;
    t_line                 line_data;

    wcf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_pixel_in  (i_pixel_in),
        .o_cfg       (cfg),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1),
        .i_s1_take   (s1_take),
        .o_ram_re    (ram_re),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata)
    );

    for (genvar g_bank = 0; g_bank < LINE_ROWS; g_bank++) begin : g_line
        wcf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[g_bank]),
            .i_waddr (ram_addr),
            .i_wdata (ram_wdata),
            .i_re    (ram_re),
            .i_raddr (ram_addr),
            .o_rdata (line_data[g_bank])
        );
    end

    wcf_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s1_take  (s1_take),
        .i_line     (line_data),
        .o_s2_valid (s2_valid),
        .o_s2       (s2),
        .o_win      (win),
        .i_s2_take  (s2_take)
    );

    wcf_arith u_arith (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_s2_valid   (s2_valid),
        .i_s2         (s2),
        .i_win        (win),
        .o_s2_take    (s2_take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last)
    );

endmodule

`default_nettype wire
